[hw/rtl/ams_pkg.sv]
// Shared constants, codes and item types of the accumulator machine step block.
package ams_pkg;

  // Memory geometry
  localparam int MEM_WORDS = 32;
  localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // Field widths
  localparam int OP_W   = 2;
  localparam int WA_W   = 5;
  localparam int WORD_W = 16;
  localparam int PC_W   = 8;
  localparam int CNT_W  = 32;
  localparam int STOP_W = 2;

  // Range limit, one bit wider than the program counter
  localparam logic [PC_W:0] MEM_LIMIT = (PC_W + 1)'(MEM_WORDS);

  // Item operations
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_EXEC    = 2'd3;

  // Stop codes
  localparam logic [STOP_W-1:0] STOP_RUN  = 2'd0;
  localparam logic [STOP_W-1:0] STOP_HALT = 2'd1;
  localparam logic [STOP_W-1:0] STOP_ZERO = 2'd2;
  localparam logic [STOP_W-1:0] STOP_OUT  = 2'd3;

  // Instruction opcodes (upper byte of the word)
  localparam logic [7:0] OPC_LOAD  = 8'h00;
  localparam logic [7:0] OPC_STORE = 8'h01;
  localparam logic [7:0] OPC_NEG   = 8'h03;
  localparam logic [7:0] OPC_JUMP  = 8'h04;
  localparam logic [7:0] OPC_RECIP = 8'h06;
  localparam logic [7:0] OPC_ADD   = 8'h0A;
  localparam logic [7:0] OPC_MUL   = 8'h0B;
  localparam logic [7:0] OPC_PRINT = 8'h0C;
  localparam logic [7:0] OPC_JNP   = 8'h0D;
  localparam logic [7:0] OPC_HALT  = 8'h0F;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WA_W-1:0]   word_addr;
    logic [WORD_W-1:0] word_data;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0]        read_data;
    logic                     printed;
    logic signed [WORD_W-1:0] print_value;
    logic [STOP_W-1:0]        stop_reason;
    logic [PC_W-1:0]          program_counter;
    logic [WORD_W-1:0]        acc_value;
    logic [CNT_W-1:0]         executed_count;
  } result_t;

endpackage

[hw/rtl/ams_if.sv]
// Valid/ready channel interfaces for items in and results out.
interface ams_in_if;
  import ams_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [WA_W-1:0]   word_addr;
  logic [WORD_W-1:0] word_data;

  modport source (output valid, output op, output word_addr, output word_data,
                  input ready);
  modport sink   (input valid, input op, input word_addr, input word_data,
                  output ready);
endinterface

interface ams_out_if;
  import ams_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [WORD_W-1:0]        read_data;
  logic                     printed;
  logic signed [WORD_W-1:0] print_value;
  logic [STOP_W-1:0]        stop_reason;
  logic [PC_W-1:0]          program_counter;
  logic [WORD_W-1:0]        acc_value;
  logic [CNT_W-1:0]         executed_count;

  modport source (output valid, output read_data, output printed, output print_value,
                  output stop_reason, output program_counter, output acc_value,
                  output executed_count, input ready);
  modport sink   (input valid, input read_data, input printed, input print_value,
                  input stop_reason, input program_counter, input acc_value,
                  input executed_count, output ready);
endinterface

[hw/rtl/ams_core.sv]
// Sequencer and word memory of the accumulator machine: fetch, operand read, execute.
module ams_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  ams_pkg::item_t  item,
  output logic            item_take,
  input  logic            out_free,
  output logic            res_load,
  output ams_pkg::result_t res
);
  import ams_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0]        state, state_next;
  logic [PC_W-1:0]   pc, pc_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic [CNT_W-1:0]  total, total_next;
  logic [STOP_W-1:0] stopped, stopped_next;
  logic [WORD_W-1:0] ir;
  logic              ir_load;
  logic              rd_ok, rd_ok_next;

  // Word memory with one write and one registered read port
  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld;
  logic [WORD_W-1:0] rd_data;
  logic              rd_vld;
  logic              we, re;
  logic [MEM_AW-1:0] w_idx, r_idx;
  logic [WORD_W-1:0] w_data;

  // Datapath helpers
  logic [PC_W-1:0]     wa8;
  logic                wa_ok, pc_ok, fetch_ok;
  logic [WORD_W-1:0]   rd_word, arg, rdata_out;
  logic [PC_W-1:0]     fetch_addr, op_addr;
  logic [7:0]          opc;
  logic [PC_W:0]       pc_inc, pc_nx;
  logic [2*WORD_W-1:0] prod;
  logic                printed, halt;

  assign wa8        = {{(PC_W-WA_W){1'b0}}, item.word_addr};
  assign wa_ok      = {1'b0, wa8} < MEM_LIMIT;
  assign pc_ok      = {1'b0, pc} < MEM_LIMIT;
  assign rd_word    = rd_vld ? rd_data : '0;
  assign fetch_addr = rd_word[PC_W-1:0];
  assign fetch_ok   = {1'b0, fetch_addr} < MEM_LIMIT;
  assign op_addr    = ir[PC_W-1:0];
  assign opc        = ir[WORD_W-1:PC_W];
  assign arg        = rd_ok ? rd_word : '0;
  assign pc_inc     = {1'b0, pc} + (PC_W + 1)'(1);
  assign prod       = acc * arg;

  // Sequencer and execute logic
  always_comb begin
    state_next   = state;
    pc_next      = pc;
    acc_next     = acc;
    total_next   = total;
    stopped_next = stopped;
    rd_ok_next   = rd_ok;
    ir_load      = 1'b0;
    item_take    = 1'b0;
    res_load     = 1'b0;
    we           = 1'b0;
    w_idx        = wa8[MEM_AW-1:0];
    w_data       = item.word_data;
    re           = 1'b0;
    r_idx        = wa8[MEM_AW-1:0];
    rdata_out    = '0;
    printed      = 1'b0;
    halt         = 1'b0;
    pc_nx        = pc_inc;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (item.op)
            OP_WRITE: begin
              if (out_free) begin
                item_take = 1'b1;
                res_load  = 1'b1;
                we        = wa_ok;
              end
            end
            OP_READ: begin
              item_take  = 1'b1;
              re         = wa_ok;
              rd_ok_next = wa_ok;
              state_next = S_READ;
            end
            OP_RESTART: begin
              if (out_free) begin
                item_take    = 1'b1;
                res_load     = 1'b1;
                pc_next      = '0;
                acc_next     = '0;
                total_next   = '0;
                stopped_next = STOP_RUN;
              end
            end
            OP_EXEC: begin
              if (stopped != STOP_RUN || !pc_ok) begin
                // stopped machine, or counter already outside memory
                if (out_free) begin
                  item_take = 1'b1;
                  res_load  = 1'b1;
                  if (stopped == STOP_RUN) begin
                    stopped_next = STOP_OUT;
                  end
                end
              end else begin
                item_take  = 1'b1;
                re         = 1'b1;
                r_idx      = pc[MEM_AW-1:0];
                state_next = S_FETCH;
              end
            end
            default: begin
              if (out_free) begin
                item_take = 1'b1;
                res_load  = 1'b1;
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          res_load   = 1'b1;
          rdata_out  = rd_ok ? rd_word : '0;
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        // latch the instruction, read its operand
        ir_load    = 1'b1;
        re         = fetch_ok;
        r_idx      = fetch_addr[MEM_AW-1:0];
        rd_ok_next = fetch_ok;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (ir == '0) begin
            stopped_next = STOP_ZERO;
          end else begin
            case (opc)
              OPC_LOAD: begin
                if (rd_ok) acc_next = arg;
              end
              OPC_STORE: begin
                we     = rd_ok;
                w_idx  = op_addr[MEM_AW-1:0];
                w_data = acc;
              end
              OPC_ADD: begin
                if (rd_ok) acc_next = acc + arg;
              end
              OPC_MUL: begin
                if (rd_ok) acc_next = prod[WORD_W-1:0];
              end
              OPC_NEG: begin
                acc_next = '0 - acc;
              end
              OPC_RECIP: begin
                if (acc != '0) acc_next = (acc == WORD_W'(1)) ? WORD_W'(1) : '0;
              end
              OPC_JUMP: begin
                pc_nx = {1'b0, op_addr};
              end
              OPC_JNP: begin
                if (acc == '0 || acc[WORD_W-1]) pc_nx = {1'b0, op_addr};
              end
              OPC_PRINT: begin
                printed = 1'b1;
              end
              OPC_HALT: begin
                halt = 1'b1;
              end
              default: begin
              end
            endcase
            if (halt) begin
              stopped_next = STOP_HALT;
            end else begin
              if (total != '1) total_next = total + CNT_W'(1);
              if (pc_nx >= MEM_LIMIT) stopped_next = STOP_OUT;
              pc_next = pc_nx[PC_W-1:0];
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result built from the state after this item
  always_comb begin
    res.read_data       = rdata_out;
    res.printed         = printed;
    res.print_value     = printed ? $signed(acc) : '0;
    res.stop_reason     = stopped_next;
    res.program_counter = pc_next;
    res.acc_value       = acc_next;
    res.executed_count  = total_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pc      <= '0;
      acc     <= '0;
      total   <= '0;
      stopped <= STOP_RUN;
      vld     <= '0;
    end else begin
      state   <= state_next;
      pc      <= pc_next;
      acc     <= acc_next;
      total   <= total_next;
      stopped <= stopped_next;
      if (we) vld[w_idx] <= 1'b1;
    end
  end

  // Memory array, read data and instruction register
  always_ff @(posedge clk) begin
    if (we) mem[w_idx] <= w_data;
    if (re) begin
      rd_data <= mem[r_idx];
      rd_vld  <= vld[r_idx];
    end
    if (ir_load) ir <= rd_word;
    rd_ok <= rd_ok_next;
  end

endmodule

[hw/rtl/accumulator_machine_step.sv]
// Top level of the accumulator machine step block: input buffer, core, result register.
//
// Items arrive on in_ch (op, word_addr, word_data) and each gives exactly one
// result on out_ch, in order. Both channels transfer on valid and ready high.
// A one-entry input buffer takes the next item while the current one is being
// worked on; a result register holds the finished result until it is taken.
// Steps in the core, from the buffered item to a loaded result register:
//   write, restart, execute on a stopped machine: result loaded as the item is taken
//   read: registered memory read, then result
//   execute: fetch the instruction word, read the operand, execute
//   with any store written back, in that order because of the two dependent
//   reads of the single-read-port word memory.
// The core finishes each item before it takes the next one.
// Reset clears the machine registers and marks every memory word as zero
// through per-word valid bits, so no clearing pass is needed.
// When out_ch stalls, the finished result stays put, the core holds its item
// in its last step and the input buffer fills, after which in_ch.ready drops.
module accumulator_machine_step (
  input logic       clk,
  input logic       rst,
  ams_in_if.sink    in_ch,
  ams_out_if.source out_ch
);
  import ams_pkg::*;

  logic    buf_valid;
  item_t   buf_item;
  logic    out_valid;
  result_t out_res;
  logic    take, load, out_free;
  result_t core_res;
  logic    in_xfer;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !buf_valid || take;
  assign out_free    = !out_valid || out_ch.ready;

  // Input buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_xfer) begin
      buf_valid <= 1'b1;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      buf_item.op        <= in_ch.op;
      buf_item.word_addr <= in_ch.word_addr;
      buf_item.word_data <= in_ch.word_data;
    end
  end

  ams_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (buf_valid),
    .item       (buf_item),
    .item_take  (take),
    .out_free   (out_free),
    .res_load   (load),
    .res        (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= core_res;
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.read_data       = out_res.read_data;
  assign out_ch.printed         = out_res.printed;
  assign out_ch.print_value     = out_res.print_value;
  assign out_ch.stop_reason     = out_res.stop_reason;
  assign out_ch.program_counter = out_res.program_counter;
  assign out_ch.acc_value       = out_res.acc_value;
  assign out_ch.executed_count  = out_res.executed_count;

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || out_ch.ready))
    else $error("result register overwritten while stalled");

  // A buffered item stays until the core takes it
  a_buf_hold: assert property (@(posedge clk) disable iff (rst)
    (buf_valid && !take) |=> buf_valid)
    else $error("buffered item lost");

  // A printed value is the accumulator that goes with it
  a_print_acc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.printed) |-> ($unsigned(out_res.print_value) == out_res.acc_value))
    else $error("print value differs from accumulator");

endmodule

[tb/tb.sv]
// Self-checking testbench for the accumulator machine step block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ams_pkg::*;

  localparam int TOTAL_ITEMS   = 1850;
  localparam int BATCH_ITEMS   = 620;
  localparam int IDLE_PCT      = 33;
  localparam int STALL_CYCLES  = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_FROM    = 1500;
  localparam int QUIET_TO      = 3000;

  logic clk;
  logic rst = 1'b1;

  ams_in_if  in_ch ();
  ams_out_if out_ch ();

  accumulator_machine_step uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Items waiting to be sent, results owed by the block
  item_t   items_to_send [$];
  result_t results_due [$];

  // Shadow copy of the machine
  logic [WORD_W-1:0] shadow_mem [MEM_WORDS];
  logic [PC_W-1:0]   shadow_pc;
  logic [WORD_W-1:0] shadow_acc;
  logic [CNT_W-1:0]  shadow_count;
  logic [STOP_W-1:0] shadow_stop;

  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned items_taken     = 0;
  int unsigned instr_run       = 0;
  int unsigned print_total     = 0;
  int unsigned stop_tally [4]  = '{0, 0, 0, 0};
  int unsigned queued_total    = 0;
  int unsigned cycle_count     = 0;
  int unsigned stall_left      = 0;
  logic        stall_done      = 1'b0;
  logic        in_fire         = 1'b0;
  logic        quiet_stretch;

  assign quiet_stretch = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task report_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // One item through the shadow machine; returns the result it must give
  task automatic run_machine_item(input item_t it, output result_t res);
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] arg;
    logic [7:0]        opc;
    logic [7:0]        addr;
    logic [PC_W:0]     next_pc;
    logic [STOP_W-1:0] stop_before;
    logic              ok;
    res = '0;
    stop_before = shadow_stop;
    case (it.op)
      OP_WRITE: begin
        if (it.word_addr < MEM_WORDS) shadow_mem[it.word_addr] = it.word_data;
      end
      OP_READ: begin
        if (it.word_addr < MEM_WORDS) res.read_data = shadow_mem[it.word_addr];
      end
      OP_RESTART: begin
        shadow_pc    = '0;
        shadow_acc   = '0;
        shadow_count = '0;
        shadow_stop  = STOP_RUN;
      end
      default: begin
        if (shadow_stop != STOP_RUN) begin
          // stopped machine: report only
        end else if (shadow_pc >= MEM_WORDS) begin
          shadow_stop = STOP_OUT;
        end else begin
          word = shadow_mem[shadow_pc];
          if (word == '0) begin
            shadow_stop = STOP_ZERO;
          end else begin
            opc     = word[15:8];
            addr    = word[7:0];
            ok      = addr < MEM_WORDS;
            arg     = ok ? shadow_mem[addr] : '0;
            next_pc = {1'b0, shadow_pc} + 1'b1;
            if (opc == OPC_HALT) begin
              shadow_stop = STOP_HALT;
            end else begin
              case (opc)
                OPC_LOAD:  if (ok) shadow_acc = arg;
                OPC_STORE: if (ok) shadow_mem[addr] = shadow_acc;
                OPC_ADD:   if (ok) shadow_acc = shadow_acc + arg;
                OPC_MUL:   if (ok) shadow_acc = shadow_acc * arg;
                OPC_NEG:   shadow_acc = ~shadow_acc + 1'b1;
                OPC_RECIP: if (shadow_acc != '0) shadow_acc = (shadow_acc == 1) ? 16'd1 : 16'd0;
                OPC_JUMP:  next_pc = {1'b0, addr};
                OPC_JNP:   if ($signed(shadow_acc) <= 0) next_pc = {1'b0, addr};
                OPC_PRINT: begin
                  res.printed     = 1'b1;
                  res.print_value = shadow_acc;
                  print_total++;
                end
                default: ;
              endcase
              instr_run++;
              if (shadow_count != '1) shadow_count = shadow_count + 1'b1;
              if (next_pc >= MEM_LIMIT) shadow_stop = STOP_OUT;
              shadow_pc = next_pc[PC_W-1:0];
            end
          end
        end
      end
    endcase
    if (stop_before == STOP_RUN && shadow_stop != STOP_RUN) stop_tally[shadow_stop]++;
    res.stop_reason     = shadow_stop;
    res.program_counter = shadow_pc;
    res.acc_value       = shadow_acc;
    res.executed_count  = shadow_count;
  endtask

  // Monitor: check results, then predict for the item taken at this edge
  always @(posedge clk) begin : monitor
    result_t want;
    item_t   taken;
    cycle_count <= cycle_count + 1;
    in_fire     <= !rst && in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report_error("result arrived with nothing expected");
        end else begin
          want = results_due.pop_front();
          check_field("read_data", out_ch.read_data, want.read_data);
          check_field("printed", out_ch.printed, want.printed);
          check_field("print_value", out_ch.print_value, want.print_value);
          check_field("stop_reason", out_ch.stop_reason, want.stop_reason);
          check_field("program_counter", out_ch.program_counter, want.program_counter);
          check_field("acc_value", out_ch.acc_value, want.acc_value);
          check_field("executed_count", out_ch.executed_count, want.executed_count);
          results_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.op        = in_ch.op;
        taken.word_addr = in_ch.word_addr;
        taken.word_data = in_ch.word_data;
        run_machine_item(taken, want);
        results_due = {results_due, want};
        items_taken++;
      end
    end
  end

  // Driver: retire the item just transferred, then offer the next or idle
  always @(negedge clk) begin : driver
    if (!rst) begin
      if (in_fire) void'(items_to_send.pop_front());
      if (!in_ch.valid || in_fire) begin
        if (items_to_send.size() != 0 && (quiet_stretch || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid     <= 1'b1;
          in_ch.op        <= items_to_send[0].op;
          in_ch.word_addr <= items_to_send[0].word_addr;
          in_ch.word_data <= items_to_send[0].word_data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure plus one long hold-off while items are queued
  always @(negedge clk) begin : receiver
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!stall_done && results_checked > 100 && items_to_send.size() > 20) begin
      stall_done   <= 1'b1;
      stall_left   <= STALL_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task queue_item(input logic [OP_W-1:0] op, input logic [WA_W-1:0] addr,
                  input logic [WORD_W-1:0] data);
    item_t it;
    it.op        = op;
    it.word_addr = addr;
    it.word_data = data;
    items_to_send = {items_to_send, it};
    queued_total++;
  endtask

  function automatic logic [7:0] known_opcode(input int unsigned k);
    case (k)
      0:       return OPC_LOAD;
      1:       return OPC_STORE;
      2:       return OPC_ADD;
      3:       return OPC_MUL;
      4:       return OPC_NEG;
      5:       return OPC_RECIP;
      6:       return OPC_JUMP;
      7:       return OPC_JNP;
      default: return OPC_PRINT;
    endcase
  endfunction

  // Mostly valid instructions; jumps mostly stay inside the program
  function automatic logic [15:0] make_instr(input int unsigned prog_len);
    int unsigned p;
    logic [7:0]  opc;
    logic [7:0]  target;
    p = $urandom_range(99);
    target = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(prog_len - 1));
    if (p < 2) return '0;
    if (p < 4) return {OPC_HALT, 8'($urandom)};
    if (p < 9) return 16'($urandom);
    opc = known_opcode($urandom_range(8));
    if (opc == OPC_JUMP || opc == OPC_JNP) return {opc, target};
    if ($urandom_range(9) == 0) return {opc, 8'($urandom)};
    return {opc, 8'($urandom_range(MEM_WORDS - 1))};
  endfunction

  // Data words leaning on the arithmetic corners
  function automatic logic [15:0] make_data();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return 16'h0001;
      5:       return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  // One random episode: a fresh program and a run through it, or plain noise
  task automatic queue_episode();
    int unsigned prog_len;
    int unsigned pick;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(20, 5)) queue_item(2'($urandom), 5'($urandom), 16'($urandom));
    end else begin
      queue_item(OP_RESTART, 5'($urandom), 16'($urandom));
      prog_len = $urandom_range(MEM_WORDS, 2);
      for (int a = 0; a < prog_len; a++) queue_item(OP_WRITE, WA_W'(a), make_instr(prog_len));
      repeat ($urandom_range(4)) queue_item(OP_WRITE, 5'($urandom), make_data());
      repeat ($urandom_range(2 * prog_len + 8, 4)) begin
        pick = $urandom_range(99);
        if (pick < 6)
          queue_item(OP_READ, 5'($urandom), 16'($urandom));
        else if (pick < 10)
          queue_item(OP_WRITE, 5'($urandom), pick[0] ? make_data() : make_instr(prog_len));
        else
          queue_item(OP_EXEC, 5'($urandom), 16'($urandom));
      end
    end
  endtask

  task wait_for_drain();
    while (items_to_send.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned batch_end;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_WRITE;
    in_ch.word_addr = '0;
    in_ch.word_data = '0;
    out_ch.ready    = 1'b0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    shadow_pc    = '0;
    shadow_acc   = '0;
    shadow_count = '0;
    shadow_stop  = STOP_RUN;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero word at reset
    queue_item(OP_EXEC, 5'd0, 16'h0000);
    // Program: load, print negative, taken jnp, multiply wrap, reciprocal of one,
    // store, negate, add with operand beyond memory, halt
    queue_item(OP_WRITE, 5'd31, 16'hFFFF);
    queue_item(OP_WRITE, 5'd0, {OPC_LOAD, 8'd31});
    queue_item(OP_WRITE, 5'd1, {OPC_PRINT, 8'd0});
    queue_item(OP_WRITE, 5'd2, {OPC_JNP, 8'd4});
    queue_item(OP_WRITE, 5'd4, {OPC_MUL, 8'd31});
    queue_item(OP_WRITE, 5'd5, {OPC_RECIP, 8'd0});
    queue_item(OP_WRITE, 5'd6, {OPC_STORE, 8'd30});
    queue_item(OP_WRITE, 5'd7, {OPC_NEG, 8'd0});
    queue_item(OP_WRITE, 5'd8, {OPC_ADD, 8'hFF});
    queue_item(OP_WRITE, 5'd9, {OPC_HALT, 8'd0});
    queue_item(OP_RESTART, 5'd0, 16'h0000);
    repeat (9) queue_item(OP_EXEC, 5'd0, 16'h0000);
    // Execute on a halted machine, then read back the stored word
    queue_item(OP_EXEC, 5'd31, 16'hFFFF);
    queue_item(OP_READ, 5'd30, 16'h0000);
    // Jump to the last word; its unknown opcode steps the counter out of memory
    queue_item(OP_WRITE, 5'd0, {OPC_JUMP, 8'd31});
    queue_item(OP_RESTART, 5'd31, 16'hFFFF);
    repeat (2) queue_item(OP_EXEC, 5'd0, 16'h0000);
    wait_for_drain();

    // Random batches, each followed by a full drain
    while (queued_total < TOTAL_ITEMS) begin
      batch_end = queued_total + BATCH_ITEMS;
      while (queued_total < batch_end && queued_total < TOTAL_ITEMS) queue_episode();
      wait_for_drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d checked results: %0d instructions run, %0d prints",
             items_taken, results_checked, instr_run, print_total);
    $display("machine stops by halt %0d, zero word %0d, leaving memory %0d; mismatches %0d",
             stop_tally[STOP_HALT], stop_tally[STOP_ZERO], stop_tally[STOP_OUT], error_count);
    if (error_count == 0) begin
      $display("accumulator_machine_step regression: pass");
    end else begin
      $display("accumulator_machine_step regression: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("accumulator_machine_step regression: fail");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ams_pkg.sv
hw/rtl/ams_if.sv
hw/rtl/ams_core.sv
hw/rtl/accumulator_machine_step.sv
tb/tb.sv
